// File: rtl/core/spi_mode0_register_transaction_master_defines.svh
// Assertion macros shared by the checker of the SPI register transaction master.
// No dependencies; included by files that assert.
`ifndef SPI_MODE0_REGISTER_TRANSACTION_MASTER_DEFINES_SVH
`define SPI_MODE0_REGISTER_TRANSACTION_MASTER_DEFINES_SVH

// Same-cycle implication, checked on the rising clock, off during reset.
`define SMTM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smtm assertion failed");

// Next-cycle implication, checked on the rising clock, off during reset.
`define SMTM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smtm assertion failed");

`endif

// File: rtl/core/smtm_pkg.sv
// Package of the SPI mode 0 register transaction master: types and constants.
// No dependencies; imported by every module of the block.
package smtm_pkg;

   localparam int WORD_BITS_DEFAULT   = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [1:0] KIND_TICK = 2'd0;
   localparam logic [1:0] KIND_LOAD = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_LOAD,
      OP_END,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] tx_byte;
      logic       miso;
   } item_type;

   typedef struct packed {
      logic       cs_n;
      logic       sck;
      logic       mosi;
      logic       busy_res;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       rx_is_status;
      logic       refused;
   } result_type;

   // Queue handshake between front and back.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: rtl/core/smtm_front.sv
// Front end: accepts transactions and classifies the kind code into an operation.
// Depends on smtm_pkg.
module smtm_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [1:0]                req_kind,
   input  logic [7:0]                req_tx_byte,
   input  logic                      req_miso,
   input  smtm_pkg::queue_status_type q_status,
   output logic                      q_push,
   output smtm_pkg::item_type        q_item
);
   import smtm_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;
   op_type   op_dec;

   always_comb begin
      case (req_kind)
         KIND_TICK: op_dec = OP_TICK;
         KIND_LOAD: op_dec = OP_LOAD;
         KIND_END:  op_dec = OP_END;
         default:   op_dec = OP_NOP;
      endcase
   end

   assign q_push   = valid_ff && !q_status.full;
   assign req_full = valid_ff && q_status.full;
   assign take     = req_push && !req_full;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (q_push) begin
         valid_in = 1'b0;
      end
      if (take) begin
         valid_in        = 1'b1;
         item_in.op      = op_dec;
         item_in.tx_byte = req_tx_byte;
         item_in.miso    = req_miso;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign q_item = item_ff;

endmodule

// File: rtl/core/smtm_queue.sv
// Short queue of classified operations between front and back.
// Depends on smtm_pkg.
module smtm_queue #(
   parameter int QUEUE_DEPTH = smtm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  smtm_pkg::item_type         push_item,
   input  logic                       pop,
   output smtm_pkg::item_type         head_item,
   output smtm_pkg::queue_status_type status
);
   import smtm_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   item_type         mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_item    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/core/smtm_back.sv
// Back end: pin-level SPI shifter state and the result register.
// Depends on smtm_pkg.
module smtm_back #(
   parameter int WORD_BITS = smtm_pkg::WORD_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  smtm_pkg::queue_status_type q_status,
   input  smtm_pkg::item_type         q_item,
   output logic                       q_pop,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output smtm_pkg::result_type       result
);
   import smtm_pkg::*;

   localparam int BL_W = $clog2(WORD_BITS + 1);
   localparam logic [BL_W-1:0] FULL_BITS = BL_W'(WORD_BITS);
   localparam logic [BL_W-1:0] ONE_BIT   = BL_W'(1);

   logic [WORD_BITS-1:0] shift_ff, shift_in;
   logic [BL_W-1:0]      bits_left_ff, bits_left_in;
   logic                 clk_high_ff, clk_high_in;
   logic                 select_ff, select_in;
   logic                 first_ff, first_in;
   logic                 data_ff, data_in;
   logic                 out_valid_ff, out_valid_in;
   result_type           out_ff, out_in;

   logic                 busy;
   logic                 rx_valid, rx_status, refused;
   logic [7:0]           rx_byte;
   logic [WORD_BITS:0]   shift_ext;
   logic [WORD_BITS+7:0] tx_ext, rx_ext;

   assign busy      = (bits_left_ff != '0);
   assign q_pop     = !q_status.empty && (!out_valid_ff || rsp_pop);
   assign rsp_empty = !out_valid_ff;
   assign result    = out_ff;

   assign shift_ext = {shift_ff, q_item.miso};
   assign tx_ext    = {{WORD_BITS{1'b0}}, q_item.tx_byte};
   assign rx_ext    = {8'd0, shift_ff};

   always_comb begin
      shift_in     = shift_ff;
      bits_left_in = bits_left_ff;
      clk_high_in  = clk_high_ff;
      select_in    = select_ff;
      first_in     = first_ff;
      data_in      = data_ff;
      rx_valid     = 1'b0;
      rx_byte      = 8'd0;
      rx_status    = 1'b0;
      refused      = 1'b0;
      case (q_item.op)
         OP_TICK: begin
            if (busy) begin
               if (!clk_high_ff) begin
                  // rising edge: drive top bit, sample miso
                  data_in     = shift_ff[WORD_BITS-1];
                  clk_high_in = 1'b1;
                  shift_in    = shift_ext[WORD_BITS-1:0];
               end else begin
                  clk_high_in  = 1'b0;
                  bits_left_in = bits_left_ff - 1'b1;
                  if (bits_left_ff == ONE_BIT) begin
                     rx_valid  = 1'b1;
                     rx_byte   = rx_ext[7:0];
                     rx_status = first_ff;
                     first_in  = 1'b0;
                  end
               end
            end
         end
         OP_LOAD: begin
            if (busy) begin
               refused = 1'b1;
            end else begin
               if (!select_ff) begin
                  select_in = 1'b1;
                  first_in  = 1'b1;
               end
               shift_in     = tx_ext[WORD_BITS-1:0];
               bits_left_in = FULL_BITS;
               clk_high_in  = 1'b0;
            end
         end
         OP_END: begin
            if (busy) begin
               refused = 1'b1;
            end else begin
               select_in = 1'b0;
               first_in  = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (q_pop) begin
         out_valid_in        = 1'b1;
         out_in.cs_n         = !select_in;
         out_in.sck          = clk_high_in;
         out_in.mosi         = data_in;
         out_in.busy_res     = (bits_left_in != '0);
         out_in.rx_valid     = rx_valid;
         out_in.rx_byte      = rx_byte;
         out_in.rx_is_status = rx_status;
         out_in.refused      = refused;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= '0;
         bits_left_ff <= '0;
         clk_high_ff  <= 1'b0;
         select_ff    <= 1'b0;
         first_ff     <= 1'b0;
         data_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            shift_ff     <= shift_in;
            bits_left_ff <= bits_left_in;
            clk_high_ff  <= clk_high_in;
            select_ff    <= select_in;
            first_ff     <= first_in;
            data_ff      <= data_in;
         end
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

endmodule

// File: rtl/core/spi_mode0_register_transaction_master.sv
// SPI mode 0 master, MSB first, that frames register transactions. Each request
// transaction is a half-bit tick (kind 0), a word load (kind 1) or an end mark
// (kind 2); kind 3 changes nothing. A load while chip select is inactive opens a
// transaction and its received word is flagged as the status byte. A word is
// shifted over 2*WORD_BITS ticks: the first tick of a pair drives MOSI with the
// top bit, raises SCK and samples MISO; the second lowers SCK. Loads and ends
// that arrive while a word is shifting are refused and change nothing. Every
// request transaction yields exactly one response transaction with the pin
// levels after it. Throughput is one transaction per clock while the queue
// is not empty and the result register is free or being popped; a request
// passes the front register, then a queue entry, then the result register
// before its response shows on the rsp_ ports. Depends on smtm_pkg,
// smtm_front, smtm_queue and smtm_back.
module spi_mode0_register_transaction_master #(
   parameter int WORD_BITS   = smtm_pkg::WORD_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = smtm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_tx_byte,
   input  logic       req_miso,
   // response channel
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_cs_n,
   output logic       rsp_sck,
   output logic       rsp_mosi,
   output logic       rsp_busy_res,
   output logic       rsp_rx_valid,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_rx_is_status,
   output logic       rsp_refused
);
   import smtm_pkg::*;

   queue_status_type q_status;
   logic             q_push, q_pop;
   item_type         front_item, head_item;
   result_type       result;

   // Front: decode kind, hold one transaction until the queue takes it.
   smtm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_kind    (req_kind),
      .req_tx_byte (req_tx_byte),
      .req_miso    (req_miso),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_item      (front_item)
   );

   // Decoupling queue: front and back stall independently.
   smtm_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .pop       (q_pop),
      .head_item (head_item),
      .status    (q_status)
   );

   // Back: shifter state and result register; pops when the result slot frees.
   smtm_back #(
      .WORD_BITS (WORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_item    (head_item),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .result    (result)
   );

   assign rsp_cs_n         = result.cs_n;
   assign rsp_sck          = result.sck;
   assign rsp_mosi         = result.mosi;
   assign rsp_busy_res     = result.busy_res;
   assign rsp_rx_valid     = result.rx_valid;
   assign rsp_rx_byte      = result.rx_byte;
   assign rsp_rx_is_status = result.rx_is_status;
   assign rsp_refused      = result.refused;

endmodule

// File: rtl/core/smtm_checker.sv
// Port-level checker for the SPI register transaction master, bound to the top.
// Depends on spi_mode0_register_transaction_master_defines.svh.
`include "spi_mode0_register_transaction_master_defines.svh"

module smtm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic       rsp_cs_n,
   input logic       rsp_sck,
   input logic       rsp_mosi,
   input logic       rsp_busy_res,
   input logic       rsp_rx_valid,
   input logic [7:0] rsp_rx_byte,
   input logic       rsp_rx_is_status,
   input logic       rsp_refused
);

   // a waiting response holds until popped
   `SMTM_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop,
      !rsp_empty && $stable({rsp_cs_n, rsp_sck, rsp_mosi, rsp_busy_res, rsp_rx_valid,
                             rsp_rx_byte, rsp_rx_is_status, rsp_refused}))

   // a completed word ends the shift
   `SMTM_ASSERT_IMPL(a_rx_idle, clock, reset, !rsp_empty && rsp_rx_valid, !rsp_busy_res && !rsp_sck)

   // status flag only with a received word
   `SMTM_ASSERT_IMPL(a_status_rx, clock, reset, !rsp_empty && rsp_rx_is_status, rsp_rx_valid)

   // shifting only inside an open transaction
   `SMTM_ASSERT_IMPL(a_busy_sel, clock, reset, !rsp_empty && rsp_busy_res, !rsp_cs_n)

   // a refusal leaves the shift running
   `SMTM_ASSERT_IMPL(a_refuse_busy, clock, reset, !rsp_empty && rsp_refused,
      rsp_busy_res && !rsp_rx_valid)

endmodule

bind spi_mode0_register_transaction_master smtm_checker u_smtm_checker (.*);

// File: sim/tb.sv
// Self-checking testbench for spi_mode0_register_transaction_master.
// Depends on smtm_pkg and the RTL; holds its own pin-level predictor and response scoreboard.
`timescale 1ns / 1ps

module tb;
   import smtm_pkg::*;

   localparam int SHIFT_BITS   = WORD_BITS_DEFAULT;
   localparam int BITS_W       = $clog2(SHIFT_BITS + 1);
   localparam int RANDOM_ITEMS = 1700;   // stimulus stops once this many real items went in
   localparam int HOLD_AT      = 500;    // long receiver hold-off starts here
   localparam int PAUSE_AT     = 1000;   // sender drains the block here
   localparam int CALM_AFTER   = 1500;   // no idling on either side from here on
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 8;      // margin after the last expected response
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_LIMIT = 10;

   // one directed row: the stimulus plus, where obvious, the pin levels typed in by hand
   typedef struct {
      item_type   stim;
      bit         has_gold;
      result_type gold;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [1:0] req_kind = KIND_TICK;
   logic [7:0] req_tx_byte = 8'h00;
   logic       req_miso = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic       rsp_cs_n;
   logic       rsp_sck;
   logic       rsp_mosi;
   logic       rsp_busy_res;
   logic       rsp_rx_valid;
   logic [7:0] rsp_rx_byte;
   logic       rsp_rx_is_status;
   logic       rsp_refused;

   // predictor state; starts out as after reset
   logic [SHIFT_BITS-1:0] spi_shift = '0;
   logic [BITS_W-1:0]     spi_bits_left = '0;
   logic                  spi_clk_level = 1'b0;
   logic                  spi_selected = 1'b0;
   logic                  spi_status_due = 1'b0;
   logic                  spi_mosi_level = 1'b0;

   result_type   expected_pins[$];   // pin levels still owed by the block, oldest first
   stim_row_type directed_rows[$];
   int           fail_count = 0;
   int           checked_count = 0;
   int           sent_count = 0;     // accepted items other than kind three
   bit           idling_on = 1'b1;

   // receiver hold-off: the sender bumps the token, the receiver counts the cycles
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int stall_left = 0;

   spi_mode0_register_transaction_master dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_kind         (req_kind),
      .req_tx_byte      (req_tx_byte),
      .req_miso         (req_miso),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_cs_n         (rsp_cs_n),
      .rsp_sck          (rsp_sck),
      .rsp_mosi         (rsp_mosi),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_rx_valid     (rsp_rx_valid),
      .rsp_rx_byte      (rsp_rx_byte),
      .rsp_rx_is_status (rsp_rx_is_status),
      .rsp_refused      (rsp_refused)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor: advances the SPI line state by one item, returns the
   // levels the block must report for it.
   // ------------------------------------------------------------------
   function automatic result_type exchange_pins(item_type it);
      result_type r;
      logic       shifting;
      r = '0;
      shifting = (spi_bits_left != 0);
      case (it.op)
         OP_TICK: begin
            if (shifting) begin
               if (!spi_clk_level) begin
                  // rising half: drive MSB, raise SCK, sample MISO into the LSB
                  spi_mosi_level = spi_shift[SHIFT_BITS-1];
                  spi_clk_level = 1'b1;
                  spi_shift = {spi_shift[SHIFT_BITS-2:0], it.miso};
               end else begin
                  spi_clk_level = 1'b0;
                  spi_bits_left = spi_bits_left - 1'b1;
                  if (spi_bits_left == 0) begin
                     r.rx_valid = 1'b1;
                     r.rx_byte = spi_shift;
                     r.rx_is_status = spi_status_due;
                     spi_status_due = 1'b0;
                  end
               end
            end
         end
         OP_LOAD: begin
            if (shifting) begin
               r.refused = 1'b1;
            end else begin
               // first load of a transaction pulls CS low; its reply is the status
               if (!spi_selected) begin
                  spi_selected = 1'b1;
                  spi_status_due = 1'b1;
               end
               spi_shift = it.tx_byte;
               spi_bits_left = BITS_W'(SHIFT_BITS);
               spi_clk_level = 1'b0;
            end
         end
         OP_END: begin
            if (shifting) begin
               r.refused = 1'b1;
            end else begin
               spi_selected = 1'b0;
               spi_status_due = 1'b0;
            end
         end
         default: ;   // kind three never touches the state, busy or not
      endcase
      r.cs_n = !spi_selected;
      r.sck = spi_clk_level;
      r.mosi = spi_mosi_level;
      r.busy_res = (spi_bits_left != 0);
      return r;
   endfunction

   function automatic item_type make_item(op_type op, logic [7:0] tx, logic miso);
      item_type it;
      it.op = op;
      it.tx_byte = tx;
      it.miso = miso;
      return it;
   endfunction

   // hand-typed levels for rows without a received byte
   function automatic result_type line_levels(bit cs_n, bit sck, bit mosi, bit busy,
                                              bit refused);
      result_type r;
      r = '0;
      r.cs_n = cs_n;
      r.sck = sck;
      r.mosi = mosi;
      r.busy_res = busy;
      r.refused = refused;
      return r;
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic string pins_text(result_type r);
      return $sformatf("cs_n=%b sck=%b mosi=%b busy=%b rx_valid=%b rx=%02h status=%b refused=%b",
                       r.cs_n, r.sck, r.mosi, r.busy_res, r.rx_valid, r.rx_byte,
                       r.rx_is_status, r.refused);
   endfunction

   task automatic note_failure(string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("[%0t] %s", $realtime, msg);
   endtask

   task automatic add_row(op_type op, logic [7:0] tx, logic miso, bit has_gold,
                          result_type gold);
      stim_row_type row;
      row.stim = make_item(op, tx, miso);
      row.has_gold = has_gold;
      row.gold = gold;
      directed_rows.push_back(row);
   endtask

   // ------------------------------------------------------------------
   // Scoreboard: one response transaction against the oldest expectation.
   // ------------------------------------------------------------------
   task automatic check_pins(result_type got);
      result_type want;
      string      bad;
      if (expected_pins.size() == 0) begin
         note_failure($sformatf("response with nothing expected: %s", pins_text(got)));
         return;
      end
      want = expected_pins.pop_front();
      bad = "";
      if (got.cs_n !== want.cs_n) bad = {bad, " cs_n"};
      if (got.sck !== want.sck) bad = {bad, " sck"};
      if (got.mosi !== want.mosi) bad = {bad, " mosi"};
      if (got.busy_res !== want.busy_res) bad = {bad, " busy_res"};
      if (got.rx_valid !== want.rx_valid) bad = {bad, " rx_valid"};
      if (got.rx_byte !== want.rx_byte) bad = {bad, " rx_byte"};
      if (got.rx_is_status !== want.rx_is_status) bad = {bad, " rx_is_status"};
      if (got.refused !== want.refused) bad = {bad, " refused"};
      if (bad != "")
         note_failure($sformatf("response %0d wrong in%s\n   expected %s\n   actual   %s",
                                checked_count, bad, pins_text(want), pins_text(got)));
      checked_count++;
   endtask

   // ------------------------------------------------------------------
   // Sender side. Push stays high from one item to the next unless a gap
   // is taken, so push never sees two updates in one time step.
   // ------------------------------------------------------------------
   task automatic push_request(item_type it, bit has_gold, result_type gold);
      result_type want;
      int         gap;
      gap = 0;
      if (idling_on && $urandom_range(0, 5) == 0)
         gap = $urandom_range(1, 3);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_kind <= it.op;
      req_tx_byte <= it.tx_byte;
      req_miso <= it.miso;
      do @(posedge clock); while (req_full);
      // accepted at this edge: advance the predictor and book the expectation
      want = exchange_pins(it);
      expected_pins.push_back(has_gold ? gold : want);
      if (it.op != OP_NOP)
         sent_count++;
   endtask

   task automatic push_plain(item_type it);
      push_request(it, 1'b0, '0);
   endtask

   // a well-formed register transaction: 1..3 bytes, each with its 16 ticks;
   // now and then a stray load/end/nop lands mid-byte, and now and then the
   // end is left out so the next load continues the open transaction
   task automatic send_register_transaction();
      int       n_bytes;
      int       stray_at;
      op_type   stray_op;
      n_bytes = $urandom_range(1, 3);
      for (int b = 0; b < n_bytes; b++) begin
         push_plain(make_item(OP_LOAD, pick_byte(), 1'($urandom)));
         stray_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2 * SHIFT_BITS - 1) : -1;
         for (int t = 0; t < 2 * SHIFT_BITS; t++) begin
            if (t == stray_at) begin
               case ($urandom_range(0, 2))
                  0: stray_op = OP_LOAD;
                  1: stray_op = OP_END;
                  default: stray_op = OP_NOP;
               endcase
               push_plain(make_item(stray_op, pick_byte(), 1'($urandom)));
            end
            push_plain(make_item(OP_TICK, 8'($urandom), 1'($urandom)));
         end
      end
      if ($urandom_range(0, 9) != 0)
         push_plain(make_item(OP_END, 8'($urandom), 1'($urandom)));
   endtask

   // ------------------------------------------------------------------
   // Receiver side: pops with random short stalls, plus one long
   // hold-off on request so the block backs up and raises full.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty)
            check_pins({rsp_cs_n, rsp_sck, rsp_mosi, rsp_busy_res, rsp_rx_valid,
                        rsp_rx_byte, rsp_rx_is_status, rsp_refused});
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // hard stop if the pipeline hangs
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      bit held;
      bit paused;
      held = 1'b0;
      paused = 1'b0;

      // Directed rows. Hand-typed levels where they are obvious; the long
      // run of ticks and the closing end go through the predictor.
      add_row(OP_TICK, 8'h00, 1'b1, 1'b1,
              line_levels(1'b1, 1'b0, 1'b0, 1'b0, 1'b0)); // tick while idle
      add_row(OP_END,  8'hA5, 1'b0, 1'b1,
              line_levels(1'b1, 1'b0, 1'b0, 1'b0, 1'b0)); // end while deselected
      add_row(OP_NOP,  8'hFF, 1'b1, 1'b1,
              line_levels(1'b1, 1'b0, 1'b0, 1'b0, 1'b0)); // kind three, idle
      add_row(OP_LOAD, 8'hFF, 1'b0, 1'b1,
              line_levels(1'b0, 1'b0, 1'b0, 1'b1, 1'b0)); // opens transaction
      add_row(OP_LOAD, 8'h00, 1'b1, 1'b1,
              line_levels(1'b0, 1'b0, 1'b0, 1'b1, 1'b1)); // load while busy
      add_row(OP_END,  8'h00, 1'b0, 1'b1,
              line_levels(1'b0, 1'b0, 1'b0, 1'b1, 1'b1)); // end while busy
      add_row(OP_TICK, 8'h00, 1'b1, 1'b1,
              line_levels(1'b0, 1'b1, 1'b1, 1'b1, 1'b0)); // first rising edge
      add_row(OP_NOP,  8'h5A, 1'b0, 1'b1,
              line_levels(1'b0, 1'b1, 1'b1, 1'b1, 1'b0)); // kind three, busy
      for (int t = 1; t < 2 * SHIFT_BITS; t++)                           // rest of status byte
         add_row(OP_TICK, 8'hFF, 1'b1, 1'b0, '0);
      add_row(OP_END, 8'hFF, 1'b1, 1'b0, '0);                            // release CS

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         push_request(directed_rows[i].stim, directed_rows[i].has_gold, directed_rows[i].gold);

      // Random part: mostly whole register transactions, some loose noise.
      while (sent_count < RANDOM_ITEMS) begin
         if (sent_count >= CALM_AFTER)
            idling_on = 1'b0;
         if (!held && sent_count >= HOLD_AT) begin
            // receiver stops popping for a while; sender keeps offering
            hold_token <= hold_token + 1;
            held = 1'b1;
         end
         if (!paused && sent_count >= PAUSE_AT) begin
            // sender waits until the block has handed back everything
            req_push <= 1'b0;
            @(posedge clock);
            wait (expected_pins.size() == 0);
            @(posedge clock);
            paused = 1'b1;
         end
         if ($urandom_range(0, 99) < 85)
            send_register_transaction();
         else
            push_plain(make_item(op_type'($urandom_range(0, 3)), pick_byte(), 1'($urandom)));
      end

      req_push <= 1'b0;
      @(posedge clock);
      wait (expected_pins.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && expected_pins.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
